// ----- sv/pdds_pkg.sv -----
// ----------------------------------------------------------------------------
// pdds_pkg
// Shared types, constants and calendar helpers for the packed date block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdds_pkg;

    localparam int YEAR_COUNT_DEF = 64;
    localparam int DN_W           = 15;
    localparam int REST_W         = 17;
    localparam int SEC_W          = 32;
    localparam int CLK_W          = 17;
    localparam int IN_W           = 80;
    localparam int OUT_W          = 80;

    localparam logic [16:0] SEC_PER_DAY = 17'(24 * 3600);

    typedef enum logic [1:0] {
        KIND_DAY_DIFF = 2'd0,
        KIND_ADD_DAYS = 2'd1,
        KIND_SEC_DIFF = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAYNUM,
        S_DAYDIFF,
        S_YEAR,
        S_MONTH,
        S_MUL1,
        S_MUL2,
        S_SECDIFF,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SUB_DAY,
        SUB_YEAR,
        SUB_MONTH,
        SUB_SEC
    } t_subsel;

    typedef struct packed {
        logic  in_fire;
        t_kind kind;
        logic  year_over;
        logic  borrow;
        logic  month_last;
        logic  out_free;
    } t_stat;

    typedef struct packed {
        logic    in_ready;
        logic    load_dn;
        t_subsel sub_sel;
        logic    day_fin;
        logic    year_step;
        logic    over_fin;
        logic    month_step;
        logic    date_fin;
        logic    mul_load;
        logic    mul_second;
        logic    sec_fin;
        logic    out_load;
    } t_ctrl;

    function automatic logic [3:0] clamp_month(input logic [3:0] m);
        logic [3:0] r;
        if (m == 4'd0) begin
            r = 4'd1;
        end else if (m > 4'd12) begin
            r = 4'd12;
        end else begin
            r = m;
        end
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m) inside
            4'd2:                   r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:                r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            r = r + 9'd1;
        end
        return r;
    endfunction

    function automatic logic [16:0] clock_sec(input logic [16:0] c);
        logic [16:0] h;
        logic [16:0] mi;
        h  = 17'(c[16:12]) * 17'd3600;
        mi = 17'(c[11:6]) * 17'd60;
        return h + mi + 17'(c[5:0]);
    endfunction

endpackage

`default_nettype wire

// ----- sv/pdds_daynum.sv -----
// ----------------------------------------------------------------------------
// pdds_daynum
// Calendar day number of a date: whole years, whole months and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module pdds_daynum (
    input  wire logic [5:0]                 i_year,
    input  wire logic [3:0]                 i_month,
    input  wire logic [4:0]                 i_day,
    input  wire logic [1:0]                 i_phase,
    output logic      [pdds_pkg::DN_W-1:0]  o_dnum
);

    logic [3:0]  mc;
    logic        leap;
    logic [4:0]  mlen;
    logic [4:0]  dc;
    logic [7:0]  lead_hi;
    logic [7:0]  lead_lo;
    logic [15:0] base;
    logic [15:0] sum;

    always_comb begin
        mc   = pdds_pkg::clamp_month(i_month);
        leap = (2'(i_year[1:0] + i_phase) == 2'd0);
        mlen = pdds_pkg::month_len(mc, leap);
        if (i_day == 5'd0) begin
            dc = 5'd1;
        end else if (i_day > mlen) begin
            dc = mlen;
        end else begin
            dc = i_day;
        end
        lead_hi = (8'(i_year) + 8'(i_phase) + 8'd3) >> 2;
        lead_lo = (8'(i_phase) + 8'd3) >> 2;
        base    = 16'(i_year) * 16'd365 + 16'(lead_hi - lead_lo);
        sum     = base + 16'(pdds_pkg::cum_days(mc, leap)) + 16'(dc) - 16'd1;
        o_dnum  = sum[pdds_pkg::DN_W-1:0];
    end

endmodule

`default_nettype wire

// ----- sv/pdds_sub.sv -----
// ----------------------------------------------------------------------------
// pdds_sub
// Shared subtract and compare unit for walks and differences.
// ----------------------------------------------------------------------------
`default_nettype none

module pdds_sub (
    input  wire logic [pdds_pkg::SEC_W-1:0] i_a,
    input  wire logic [pdds_pkg::SEC_W-1:0] i_b,
    output logic      [pdds_pkg::SEC_W-1:0] o_diff,
    output logic                            o_borrow
);

    logic [pdds_pkg::SEC_W:0] full;

    always_comb begin
        full     = {1'b0, i_a} - {1'b0, i_b};
        o_diff   = full[pdds_pkg::SEC_W-1:0];
        o_borrow = full[pdds_pkg::SEC_W];
    end

endmodule

`default_nettype wire

// ----- sv/pdds_fsm.sv -----
// ----------------------------------------------------------------------------
// pdds_fsm
// Sequencer that steps the shared unit through one item's operation.
// ----------------------------------------------------------------------------
`default_nettype none

module pdds_fsm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pdds_pkg::t_stat i_stat,
    output pdds_pkg::t_ctrl      o_ctrl
);

    pdds_pkg::t_state r_state;
    pdds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdds_pkg::S_IDLE: begin
                if (i_stat.in_fire) n_state = pdds_pkg::S_DAYNUM;
            end
            pdds_pkg::S_DAYNUM: begin
                unique case (i_stat.kind)
                    pdds_pkg::KIND_DAY_DIFF: n_state = pdds_pkg::S_DAYDIFF;
                    pdds_pkg::KIND_ADD_DAYS: n_state = pdds_pkg::S_YEAR;
                    pdds_pkg::KIND_SEC_DIFF: n_state = pdds_pkg::S_MUL1;
                    default:                 n_state = pdds_pkg::S_DONE;
                endcase
            end
            pdds_pkg::S_DAYDIFF: n_state = pdds_pkg::S_DONE;
            pdds_pkg::S_YEAR: begin
                if (i_stat.year_over) begin
                    n_state = pdds_pkg::S_DONE;
                end else if (i_stat.borrow) begin
                    n_state = pdds_pkg::S_MONTH;
                end
            end
            pdds_pkg::S_MONTH: begin
                if (i_stat.month_last || i_stat.borrow) n_state = pdds_pkg::S_DONE;
            end
            pdds_pkg::S_MUL1:    n_state = pdds_pkg::S_MUL2;
            pdds_pkg::S_MUL2:    n_state = pdds_pkg::S_SECDIFF;
            pdds_pkg::S_SECDIFF: n_state = pdds_pkg::S_DONE;
            pdds_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = pdds_pkg::S_IDLE;
            end
            default: n_state = pdds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.sub_sel = pdds_pkg::SUB_DAY;
        unique case (r_state)
            pdds_pkg::S_IDLE:    o_ctrl.in_ready = 1'b1;
            pdds_pkg::S_DAYNUM:  o_ctrl.load_dn  = 1'b1;
            pdds_pkg::S_DAYDIFF: o_ctrl.day_fin  = 1'b1;
            pdds_pkg::S_YEAR: begin
                o_ctrl.sub_sel   = pdds_pkg::SUB_YEAR;
                o_ctrl.over_fin  = i_stat.year_over;
                o_ctrl.year_step = !i_stat.year_over && !i_stat.borrow;
            end
            pdds_pkg::S_MONTH: begin
                o_ctrl.sub_sel    = pdds_pkg::SUB_MONTH;
                o_ctrl.date_fin   = i_stat.month_last || i_stat.borrow;
                o_ctrl.month_step = !i_stat.month_last && !i_stat.borrow;
            end
            pdds_pkg::S_MUL1: o_ctrl.mul_load = 1'b1;
            pdds_pkg::S_MUL2: begin
                o_ctrl.mul_load   = 1'b1;
                o_ctrl.mul_second = 1'b1;
            end
            pdds_pkg::S_SECDIFF: begin
                o_ctrl.sub_sel = pdds_pkg::SUB_SEC;
                o_ctrl.sec_fin = 1'b1;
            end
            pdds_pkg::S_DONE: o_ctrl.out_load = i_stat.out_free;
            default: o_ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/packed_date_day_and_second_arith.sv -----
// ----------------------------------------------------------------------------
// packed_date_day_and_second_arith
// Day difference, add days and second difference on packed calendar dates.
// ----------------------------------------------------------------------------
// One item is worked at a time; o_tready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// item is taken. A day difference subtracts the two day numbers, a second
// difference uses one shared multiplier twice, then the shared subtractor,
// and add days walks whole years and then whole months: the shared
// subtractor takes off one year or one month per cycle. A date past the
// last year ends the walk once YEAR_COUNT years are walked. A finished
// result waits in the sequencer until the previous one leaves the output
// register. Kind 3 gives an all-zero result.
`default_nettype none

module packed_date_day_and_second_arith #(
    parameter int YEAR_COUNT = pdds_pkg::YEAR_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_data,   // leap_phase
    input  wire logic                        i_tvalid,
    output logic                             o_tready,
    // first_year, first_month, first_day, first_clock, second_year,
    // second_month, second_day, second_clock, day_count
    input  wire logic [pdds_pkg::IN_W-1:0]   i_tdata,
    input  wire logic [1:0]                  i_tuser,      // kind
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    // day_diff, sec_diff, result_year, result_month, result_day, result_clock
    output logic      [pdds_pkg::OUT_W-1:0]  o_tdata,
    output logic      [0:0]                  o_tuser       // out_of_range
);

    localparam int YW = $clog2(YEAR_COUNT + 1);

    pdds_pkg::t_stat stat;
    pdds_pkg::t_ctrl ctrl;

    logic [1:0]                  r_phase;
    pdds_pkg::t_kind             r_kind;
    logic [5:0]                  r_f_year;
    logic [3:0]                  r_f_month;
    logic [4:0]                  r_f_day;
    logic [pdds_pkg::CLK_W-1:0]  r_f_clock;
    logic [5:0]                  r_s_year;
    logic [3:0]                  r_s_month;
    logic [4:0]                  r_s_day;
    logic [pdds_pkg::CLK_W-1:0]  r_s_clock;
    logic [15:0]                 r_count;
    logic [pdds_pkg::DN_W-1:0]   r_n1;
    logic [pdds_pkg::DN_W-1:0]   r_n2;
    logic [pdds_pkg::REST_W-1:0] r_rest;
    logic [YW-1:0]               r_y;
    logic [1:0]                  r_yph;
    logic [3:0]                  r_m;
    logic [pdds_pkg::SEC_W-1:0]  r_s1;
    logic [pdds_pkg::SEC_W-1:0]  r_s2;
    logic [15:0]                 r_day_diff;
    logic [pdds_pkg::SEC_W-1:0]  r_sec_diff;
    logic [5:0]                  r_res_year;
    logic [3:0]                  r_res_month;
    logic [4:0]                  r_res_day;
    logic [pdds_pkg::CLK_W-1:0]  r_res_clock;
    logic                        r_res_oor;
    logic                        r_out_valid;
    logic [pdds_pkg::OUT_W-1:0]  r_o_tdata;
    logic                        r_o_oor;

    logic [pdds_pkg::DN_W-1:0]   dn1;
    logic [pdds_pkg::DN_W-1:0]   dn2;
    logic                        leap_y;
    logic [8:0]                  ylen;
    logic [4:0]                  mlen;
    logic [pdds_pkg::SEC_W-1:0]  sub_a;
    logic [pdds_pkg::SEC_W-1:0]  sub_b;
    logic [pdds_pkg::SEC_W-1:0]  sub_diff;
    logic                        sub_borrow;
    logic [pdds_pkg::SEC_W-1:0]  prod;

    pdds_daynum u_dn1 (
        .i_year  (r_f_year),
        .i_month (r_f_month),
        .i_day   (r_f_day),
        .i_phase (r_phase),
        .o_dnum  (dn1)
    );

    pdds_daynum u_dn2 (
        .i_year  (r_s_year),
        .i_month (r_s_month),
        .i_day   (r_s_day),
        .i_phase (r_phase),
        .o_dnum  (dn2)
    );

    pdds_sub u_sub (
        .i_a      (sub_a),
        .i_b      (sub_b),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    pdds_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    always_comb begin
        leap_y = (r_yph == 2'd0);
        ylen   = leap_y ? 9'd366 : 9'd365;
        mlen   = pdds_pkg::month_len(r_m, leap_y);
        case (ctrl.sub_sel)
            pdds_pkg::SUB_YEAR: begin
                sub_a = 32'(r_rest);
                sub_b = 32'(ylen);
            end
            pdds_pkg::SUB_MONTH: begin
                sub_a = 32'(r_rest);
                sub_b = 32'(mlen);
            end
            pdds_pkg::SUB_SEC: begin
                sub_a = r_s2;
                sub_b = r_s1;
            end
            default: begin
                sub_a = 32'(r_n2);
                sub_b = 32'(r_n1);
            end
        endcase
        if (ctrl.mul_second) begin
            prod = 32'(r_n2) * 32'(pdds_pkg::SEC_PER_DAY)
                 + 32'(pdds_pkg::clock_sec(r_s_clock));
        end else begin
            prod = 32'(r_n1) * 32'(pdds_pkg::SEC_PER_DAY)
                 + 32'(pdds_pkg::clock_sec(r_f_clock));
        end
    end

    always_comb begin
        stat.in_fire    = i_tvalid && ctrl.in_ready;
        stat.kind       = r_kind;
        stat.year_over  = (r_y >= YW'(YEAR_COUNT));
        stat.borrow     = sub_borrow;
        stat.month_last = (r_m == 4'd12);
        stat.out_free   = !r_out_valid || i_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (i_cfg_valid) begin
            r_phase <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.in_fire) begin
            r_kind    <= pdds_pkg::t_kind'(i_tuser);
            r_f_year  <= i_tdata[5:0];
            r_f_month <= i_tdata[9:6];
            r_f_day   <= i_tdata[14:10];
            r_f_clock <= i_tdata[31:15];
            r_s_year  <= i_tdata[37:32];
            r_s_month <= i_tdata[41:38];
            r_s_day   <= i_tdata[46:42];
            r_s_clock <= i_tdata[63:47];
            r_count   <= i_tdata[79:64];
        end
        if (ctrl.load_dn) begin
            r_n1        <= dn1;
            r_n2        <= dn2;
            r_rest      <= 17'(dn1) + 17'(r_count);
            r_y         <= '0;
            r_yph       <= r_phase;
            r_m         <= 4'd1;
            r_day_diff  <= '0;
            r_sec_diff  <= '0;
            r_res_year  <= '0;
            r_res_month <= '0;
            r_res_day   <= '0;
            r_res_clock <= '0;
            r_res_oor   <= 1'b0;
        end
        if (ctrl.day_fin) begin
            if (sub_borrow) begin
                r_day_diff <= '0;
            end else if (sub_diff[31:16] != 16'd0) begin
                r_day_diff <= 16'hffff;
            end else begin
                r_day_diff <= sub_diff[15:0];
            end
        end
        if (ctrl.year_step) begin
            r_rest <= sub_diff[pdds_pkg::REST_W-1:0];
            r_y    <= r_y + YW'(1);
            r_yph  <= r_yph + 2'd1;
        end
        if (ctrl.over_fin) begin
            r_res_year  <= 6'(YEAR_COUNT - 1);
            r_res_month <= 4'd12;
            r_res_day   <= 5'd31;
            r_res_clock <= r_f_clock;
            r_res_oor   <= 1'b1;
        end
        if (ctrl.month_step) begin
            r_rest <= sub_diff[pdds_pkg::REST_W-1:0];
            r_m    <= r_m + 4'd1;
        end
        if (ctrl.date_fin) begin
            r_res_year  <= 6'(r_y);
            r_res_month <= r_m;
            r_res_day   <= 5'(r_rest + 17'd1);
            r_res_clock <= r_f_clock;
            r_res_oor   <= 1'b0;
        end
        if (ctrl.mul_load) begin
            if (ctrl.mul_second) begin
                r_s2 <= prod;
            end else begin
                r_s1 <= prod;
            end
        end
        if (ctrl.sec_fin) begin
            r_sec_diff <= sub_borrow ? '0 : sub_diff;
        end
        if (ctrl.out_load) begin
            r_o_tdata <= {r_res_clock, r_res_day, r_res_month, r_res_year,
                          r_sec_diff, r_day_diff};
            r_o_oor   <= r_res_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_tready    = ctrl.in_ready;
    assign o_tvalid    = r_out_valid;
    assign o_tdata     = r_o_tdata;
    assign o_tuser     = r_o_oor;

endmodule

`default_nettype wire

// ----- sv/pdds_check.sv -----
// ----------------------------------------------------------------------------
// pdds_check
// Port-level checks for the packed date block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdds_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_tvalid,
    input wire logic        o_tready,
    input wire logic        o_tvalid,
    input wire logic        i_tready,
    input wire logic [79:0] o_tdata,
    input wire logic [0:0]  o_tuser
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tvalid && o_tready) |=> !o_tready)
        else $error("input taken while an item is still being worked");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> (o_tvalid && $stable(o_tdata) && $stable(o_tuser)))
        else $error("stalled result changed");

    a_over_is_year_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser[0]) |-> (o_tdata[57:54] == 4'd12 && o_tdata[62:58] == 5'd31))
        else $error("out of range result is not the last day of the year");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tdata[15:0] != 16'd0) |-> (o_tdata[47:16] == 32'd0 &&
                                                   o_tdata[57:54] == 4'd0))
        else $error("result carries fields of more than one operation");

endmodule

bind packed_date_day_and_second_arith pdds_check u_pdds_check (.*);

`default_nettype wire

// ----- bench/date_arith_checker.sv -----
// ----------------------------------------------------------------------------
// date_arith_checker
// Watches the register, input and result channels of the packed date block,
// works out the result of each accepted item from its own calendar model
// under the current leap phase, and compares every accepted result field by
// field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module date_arith_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [1:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [pdds_pkg::IN_W-1:0]   i_in_data,
    input  logic [1:0]                  i_in_kind,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [pdds_pkg::OUT_W-1:0]  i_out_data,
    input  logic [0:0]                  i_out_flag,
    output int                          o_fail_count,
    output int                          o_pending
);
    import pdds_pkg::*;

    localparam int          YEAR_SPAN   = YEAR_COUNT_DEF;
    localparam int unsigned DAY_SECONDS = 86400;

    typedef struct packed {
        logic        over;
        logic [16:0] clock;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [5:0]  year;
        logic [31:0] sec_diff;
        logic [15:0] day_diff;
    } t_date_result;

    t_date_result awaited_date_results[$];
    logic [1:0]   leap_phase;
    int           fail_total;
    int           result_index;

    function automatic bit is_leap(int unsigned y, logic [1:0] ph);
        return ((y + ph) % 4) == 0;
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned m,
                                               logic [1:0] ph);
        int unsigned len;
        case (m)
            2:           len = is_leap(y, ph) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic int unsigned year_days(int unsigned y, logic [1:0] ph);
        return is_leap(y, ph) ? 366 : 365;
    endfunction

    function automatic int unsigned day_index(logic [5:0] y, logic [3:0] m,
                                              logic [4:0] d, logic [1:0] ph);
        int unsigned yr;
        int unsigned mon;
        int unsigned dom;
        int unsigned n;
        int unsigned k;
        yr  = y;
        mon = (m == 4'd0) ? 1 : (m > 4'd12) ? 12 : m;
        dom = (d == 5'd0) ? 1 : d;
        if (dom > month_days(yr, mon, ph)) begin
            dom = month_days(yr, mon, ph);
        end
        n = yr * 365 + (yr + ph + 3) / 4 - (ph + 3) / 4;
        for (k = 1; k < mon; k++) begin
            n += month_days(yr, k, ph);
        end
        return n + dom - 1;
    endfunction

    function automatic int unsigned clock_secs(logic [16:0] c);
        int unsigned h;
        int unsigned mi;
        int unsigned s;
        h  = c[16:12];
        mi = c[11:6];
        s  = c[5:0];
        return h * 3600 + mi * 60 + s;
    endfunction

    function automatic t_date_result date_arith_result(t_kind k,
                                                       logic [pdds_pkg::IN_W-1:0] d,
                                                       logic [1:0] ph);
        t_date_result r;
        int unsigned  n1;
        int unsigned  n2;
        int unsigned  rest;
        int unsigned  y;
        int unsigned  m;
        longint unsigned s1;
        longint unsigned s2;
        longint unsigned diff;
        r  = '0;
        n1 = day_index(d[5:0], d[9:6], d[14:10], ph);
        n2 = day_index(d[37:32], d[41:38], d[46:42], ph);
        case (k)
            KIND_DAY_DIFF: begin
                diff = (n2 > n1) ? n2 - n1 : 0;
                r.day_diff = (diff > 64'hffff) ? 16'hffff : 16'(diff);
            end
            KIND_ADD_DAYS: begin
                rest = n1 + d[79:64];
                y = 0;
                while (y < YEAR_SPAN && rest >= year_days(y, ph)) begin
                    rest -= year_days(y, ph);
                    y++;
                end
                if (y >= YEAR_SPAN) begin
                    r.year  = 6'(YEAR_SPAN - 1);
                    r.month = 4'd12;
                    r.day   = 5'd31;
                    r.over  = 1'b1;
                end else begin
                    m = 1;
                    while (m < 12 && rest >= month_days(y, m, ph)) begin
                        rest -= month_days(y, m, ph);
                        m++;
                    end
                    r.year  = 6'(y);
                    r.month = 4'(m);
                    r.day   = 5'(rest + 1);
                end
                r.clock = d[31:15];
            end
            KIND_SEC_DIFF: begin
                s1 = 64'(n1) * DAY_SECONDS + 64'(clock_secs(d[31:15]));
                s2 = 64'(n2) * DAY_SECONDS + 64'(clock_secs(d[63:47]));
                diff = (s2 > s1) ? s2 - s1 : 0;
                r.sec_diff = (diff > 64'hffffffff) ? 32'hffffffff : 32'(diff);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        if (fail_total < 100) begin
            $display("%0t: result %0d %s got 0x%0h want 0x%0h", $time, result_index,
                     field, got, want);
        end
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_date_result got;
        t_date_result want;
        if (!i_rst_n) begin
            leap_phase = 2'd0;
            awaited_date_results.delete();
            fail_total   = 0;
            result_index = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                leap_phase = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got = t_date_result'({i_out_flag, i_out_data});
                if (awaited_date_results.size() == 0) begin
                    report_mismatch("unexpected item", 64'(i_out_data), 0);
                end else begin
                    want = awaited_date_results.pop_front();
                    if (got.day_diff !== want.day_diff)
                        report_mismatch("day_diff", got.day_diff, want.day_diff);
                    if (got.sec_diff !== want.sec_diff)
                        report_mismatch("sec_diff", got.sec_diff, want.sec_diff);
                    if (got.year !== want.year)
                        report_mismatch("result_year", got.year, want.year);
                    if (got.month !== want.month)
                        report_mismatch("result_month", got.month, want.month);
                    if (got.day !== want.day)
                        report_mismatch("result_day", got.day, want.day);
                    if (got.clock !== want.clock)
                        report_mismatch("result_clock", got.clock, want.clock);
                    if (got.over !== want.over)
                        report_mismatch("out_of_range", got.over, want.over);
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready) begin
                awaited_date_results.push_back(
                    date_arith_result(t_kind'(i_in_kind), i_in_data, leap_phase));
            end
        end
        o_pending    <= awaited_date_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- bench/tb_packed_date_day_and_second_arith.sv -----
// ----------------------------------------------------------------------------
// tb_packed_date_day_and_second_arith
// Drives directed and random date items through the packed date block under
// several leap phases, with random idling on both streams and one long
// receiver hold-off, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_packed_date_day_and_second_arith;
    import pdds_pkg::*;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         PHASE_ITEMS    = 400;
    localparam logic [1:0] LEAP_PLAN [4]  = '{2'd3, 2'd1, 2'd2, 2'd0};

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [IN_W-1:0]   in_data;
    logic [1:0]        in_kind;
    logic              out_valid;
    logic              out_ready;
    logic [OUT_W-1:0]  out_data;
    logic [0:0]        out_flag;
    int                fail_count;
    int                pending;
    int                results_seen;

    packed_date_day_and_second_arith dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_tvalid    (in_valid),
        .o_tready    (in_ready),
        .i_tdata     (in_data),
        .i_tuser     (in_kind),
        .o_tvalid    (out_valid),
        .i_tready    (out_ready),
        .o_tdata     (out_data),
        .o_tuser     (out_flag)
    );

    date_arith_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_in_kind    (in_kind),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_out_flag   (out_flag),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_W-1:0] pack_dates(
        logic [5:0] y1, logic [3:0] m1, logic [4:0] d1, logic [16:0] c1,
        logic [5:0] y2, logic [3:0] m2, logic [4:0] d2, logic [16:0] c2,
        logic [15:0] count);
        return {count, c2, d2, m2, y2, c1, d1, m1, y1};
    endfunction

    function automatic logic [16:0] random_clock();
        if ($urandom_range(0, 9) == 0) return 17'($urandom);
        return {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                6'($urandom_range(0, 59))};
    endfunction

    task automatic random_date_item(output t_kind k, output logic [IN_W-1:0] d);
        logic [5:0]  y1;
        logic [5:0]  y2;
        logic [3:0]  m1;
        logic [3:0]  m2;
        logic [4:0]  d1;
        logic [4:0]  d2;
        logic [15:0] count;
        int          sel;
        sel = $urandom_range(0, 99);
        k = (sel < 30) ? KIND_DAY_DIFF : (sel < 60) ? KIND_ADD_DAYS :
            (sel < 95) ? KIND_SEC_DIFF : KIND_NONE;
        y1 = 6'($urandom_range(0, 63));
        m1 = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
        d1 = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
        if ($urandom_range(0, 1) == 0) begin
            y2 = 6'(int'(y1) + $urandom_range(0, 2) - 1);
            m2 = ($urandom_range(0, 1) == 0) ? m1 : 4'($urandom_range(1, 12));
            d2 = ($urandom_range(0, 1) == 0) ? d1 : 5'($urandom_range(1, 31));
        end else begin
            y2 = 6'($urandom_range(0, 63));
            m2 = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
            d2 = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
        end
        sel = $urandom_range(0, 9);
        count = (sel < 4) ? 16'($urandom_range(0, 400)) :
                (sel < 7) ? 16'($urandom_range(0, 24000)) : 16'($urandom);
        d = pack_dates(y1, m1, d1, random_clock(), y2, m2, d2, random_clock(), count);
    endtask

    task automatic send_date_item(input t_kind k, input logic [IN_W-1:0] d,
                                  input bit no_gap);
        int gap;
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        in_kind  <= k;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_leap_phase(input logic [1:0] ph);
        cfg_valid <= 1'b1;
        cfg_data  <= ph;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            results_seen <= 0;
        end else if (out_valid && out_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // receiver: random hold-offs, free-running stretches, one long hold
    initial begin
        int  rx_wait;
        int  rx_free;
        bit  held;
        rx_wait = 0;
        rx_free = 0;
        held    = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held && results_seen >= 300) begin
                held    = 1;
                rx_wait = 400;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (rx_free > 0) begin
                    rx_free--;
                end else if ($urandom_range(0, 31) == 0) begin
                    rx_free = $urandom_range(50, 200);
                end else begin
                    rx_wait = gap_len();
                end
            end
        end
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_kind           k;
        logic [IN_W-1:0] d;
        int              p;
        int              i;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 2'd0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        in_kind   <= KIND_DAY_DIFF;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_date_item(KIND_DAY_DIFF, pack_dates(0, 1, 1, 0, 0, 1, 1, 0, 0), 0);
        send_date_item(KIND_DAY_DIFF, pack_dates(0, 1, 1, 0, 63, 12, 31, 0, 0), 0);
        send_date_item(KIND_DAY_DIFF, pack_dates(63, 12, 31, 0, 0, 1, 1, 0, 0), 0);
        send_date_item(KIND_DAY_DIFF, pack_dates(5, 0, 0, 0, 5, 15, 31, 0, 0), 0);
        send_date_item(KIND_DAY_DIFF, pack_dates(4, 2, 31, 0, 5, 4, 31, 0, 0), 0);
        send_date_item(KIND_DAY_DIFF, '1, 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(0, 1, 1, 0, 0, 1, 1, 0, 0), 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(0, 1, 1, 17'd98043, 0, 1, 1, 0, 23375), 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(0, 1, 1, 17'd12345, 0, 1, 1, 0, 23376), 0);
        send_date_item(KIND_ADD_DAYS,
                       pack_dates(63, 12, 31, 17'h1ffff, 0, 1, 1, 0, 16'hffff), 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(0, 1, 31, 0, 0, 1, 1, 0, 1), 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(4, 2, 28, 17'd98043, 0, 1, 1, 0, 1), 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(3, 12, 31, 0, 0, 1, 1, 0, 1), 0);
        send_date_item(KIND_ADD_DAYS, pack_dates(7, 13, 0, 0, 0, 1, 1, 0, 59), 0);
        send_date_item(KIND_ADD_DAYS, '0, 0);
        send_date_item(KIND_SEC_DIFF, pack_dates(0, 1, 1, 0, 63, 12, 31, 17'd98043, 0), 0);
        send_date_item(KIND_SEC_DIFF,
                       pack_dates(9, 6, 15, 17'd4000, 9, 6, 15, 17'd4000, 0), 0);
        send_date_item(KIND_SEC_DIFF,
                       pack_dates(9, 6, 15, 17'd4000, 9, 6, 15, 17'd3999, 0), 0);
        send_date_item(KIND_SEC_DIFF, pack_dates(9, 6, 15, 0, 9, 6, 15, 17'h1ffff, 0), 0);
        send_date_item(KIND_SEC_DIFF, pack_dates(9, 6, 15, 17'h1ffff, 9, 6, 16, 0, 0), 0);
        send_date_item(KIND_NONE, '1, 0);
        in_valid <= 1'b0;

        for (p = 0; p < 5; p++) begin
            if (p > 0) begin
                wait_drained();
                write_leap_phase(LEAP_PLAN[p-1]);
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                random_date_item(k, d);
                send_date_item(k, d, (i % 200) < 40);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
